### rtl/core/nim_pkg.sv
`timescale 1ns / 1ps

package nim_pkg;

  // Store geometry.
  localparam int MAX_LIST_LEN = 32;
  localparam int IDX_W        = $clog2(MAX_LIST_LEN);
  localparam int LEN_W        = $clog2(MAX_LIST_LEN + 1);

  // Field widths.
  localparam int RANK_W  = 16;
  localparam int NCNT_W  = 24;
  localparam int SUM_W   = 29;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Input opcodes.
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // One stored list entry.
  typedef struct packed {
    logic [RANK_W-1:0] pre;
    logic [RANK_W-1:0] post;
    logic [NCNT_W-1:0] cnt;
  } entry_t;

  // Merge sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_ACC,
    ST_FLUSH,
    ST_SUMM
  } state_t;

  // Saturating add of a node count onto a running sum.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [NCNT_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - NCNT_W){1'b0}}, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

### rtl/core/nlist_intersection_merge.sv
`timescale 1ns / 1ps

// Node-list intersection merge.
// Input channel (in_valid / in_stall) carries one command word: load an entry
// into list A, load an entry into list B, run the merge, or do nothing. Loads
// and no-ops produce no result; in_stall stays low while the block is idle.
// A run walks both lists with two pointers through one shared sequencer. Each
// walk step is a registered store read, then a compare, and a step that credits
// a descendant adds an accumulate step for the shared saturating adder. The
// walk stops once either pointer leaves its list; after the run word is taken
// in_stall stays high until the summary word is emitted, including while the
// block waits on out_stall.
// Result channel (out_valid / out_stall) carries the merged ancestor entries in
// order, then one summary word with total support, the frequent flag and last.
// A single output register holds each word; when the receiver stalls, the walk
// waits at the next word to emit and the held word does not change.
// cfg_we / cfg_wdata write min_support; write it only while the block is idle.
// Synchronous reset clears both list lengths, min_support and the output
// valid; the list stores themselves are not cleared.
module nlist_intersection_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  // Command channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_op,
  input  logic [nim_pkg::RANK_W-1:0] in_pre_order,
  input  logic [nim_pkg::RANK_W-1:0] in_post_order,
  input  logic [nim_pkg::NCNT_W-1:0] in_node_count,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nim_pkg::RANK_W-1:0] out_pre_order,
  output logic [nim_pkg::RANK_W-1:0] out_post_order,
  output logic [nim_pkg::SUM_W-1:0]  out_count,
  output logic                       out_is_summary,
  output logic [nim_pkg::SUM_W-1:0]  out_total_support,
  output logic                       out_frequent,
  output logic                       out_last,
  // Configuration.
  input  logic                       cfg_we,
  input  logic [nim_pkg::SUM_W-1:0]  cfg_wdata
);

  localparam int IDX_W = nim_pkg::IDX_W;
  localparam int LEN_W = nim_pkg::LEN_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(nim_pkg::MAX_LIST_LEN);

  // List stores.
  nim_pkg::entry_t mem_a [nim_pkg::MAX_LIST_LEN];
  nim_pkg::entry_t mem_b [nim_pkg::MAX_LIST_LEN];

  nim_pkg::state_t state_r, state_nxt;
  logic [LEN_W-1:0] len_a_r, len_a_nxt;
  logic [LEN_W-1:0] len_b_r, len_b_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0] j_r, j_nxt;
  logic             have_r, have_nxt;
  logic [nim_pkg::RANK_W-1:0] cur_pre_r, cur_pre_nxt;
  logic [nim_pkg::RANK_W-1:0] cur_post_r, cur_post_nxt;
  logic [nim_pkg::SUM_W-1:0]  cur_cnt_r, cur_cnt_nxt;
  logic [nim_pkg::SUM_W-1:0]  total_r, total_nxt;
  logic [nim_pkg::SUM_W-1:0]  min_support_r;
  nim_pkg::entry_t a_rd_r, b_rd_r;

  logic out_valid_r;
  logic [nim_pkg::RANK_W-1:0] out_pre_r, out_post_r;
  logic [nim_pkg::SUM_W-1:0]  out_cnt_r, out_tot_r;
  logic out_summ_r, out_freq_r, out_last_r;

  logic in_acc;
  logic out_free;
  logic emit_entry;
  logic emit_summ;
  logic [nim_pkg::SUM_W-1:0] add_a;
  logic [nim_pkg::SUM_W-1:0] add_sum;
  logic [LEN_W-1:0] i_inc, j_inc;
  logic is_desc, same_cur;

  assign in_stall = (state_r != nim_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Shared saturating adder: running total in the accumulate step, the
  // current merged count in the compare step.
  assign add_a   = (state_r == nim_pkg::ST_ACC) ? total_r : cur_cnt_r;
  assign add_sum = nim_pkg::sat_add(add_a, b_rd_r.cnt);

  assign i_inc    = i_r + LEN_W'(1);
  assign j_inc    = j_r + LEN_W'(1);
  assign is_desc  = (a_rd_r.pre < b_rd_r.pre) && (a_rd_r.post > b_rd_r.post);
  assign same_cur = have_r && (cur_pre_r == a_rd_r.pre) && (cur_post_r == a_rd_r.post);

  // Store writes and registered reads.
  always_ff @(posedge clk) begin
    if (in_acc && (in_op == nim_pkg::OP_LOAD_A) && (len_a_r < MAX_LEN)) begin
      mem_a[len_a_r[IDX_W-1:0]] <= '{pre: in_pre_order, post: in_post_order,
                                     cnt: in_node_count};
    end
    if (in_acc && (in_op == nim_pkg::OP_LOAD_B) && (len_b_r < MAX_LEN)) begin
      mem_b[len_b_r[IDX_W-1:0]] <= '{pre: in_pre_order, post: in_post_order,
                                     cnt: in_node_count};
    end
    a_rd_r <= mem_a[i_r[IDX_W-1:0]];
    b_rd_r <= mem_b[j_r[IDX_W-1:0]];
  end

  // Sequencer state and walk registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nim_pkg::ST_IDLE;
      len_a_r <= '0;
      len_b_r <= '0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_a_r <= len_a_nxt;
      len_b_r <= len_b_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cur_pre_r  <= cur_pre_nxt;
    cur_post_r <= cur_post_nxt;
    cur_cnt_r  <= cur_cnt_nxt;
    total_r    <= total_nxt;
  end

  // Next state and emit requests.
  always_comb begin
    state_nxt    = state_r;
    len_a_nxt    = len_a_r;
    len_b_nxt    = len_b_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    have_nxt     = have_r;
    cur_pre_nxt  = cur_pre_r;
    cur_post_nxt = cur_post_r;
    cur_cnt_nxt  = cur_cnt_r;
    total_nxt    = total_r;
    emit_entry   = 1'b0;
    emit_summ    = 1'b0;

    unique case (state_r)
      nim_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            nim_pkg::OP_LOAD_A: begin
              if (len_a_r < MAX_LEN) len_a_nxt = len_a_r + LEN_W'(1);
            end
            nim_pkg::OP_LOAD_B: begin
              if (len_b_r < MAX_LEN) len_b_nxt = len_b_r + LEN_W'(1);
            end
            nim_pkg::OP_RUN: begin
              i_nxt     = '0;
              j_nxt     = '0;
              have_nxt  = 1'b0;
              total_nxt = '0;
              if ((len_a_r == '0) || (len_b_r == '0)) begin
                state_nxt = nim_pkg::ST_FLUSH;
              end else begin
                state_nxt = nim_pkg::ST_FETCH;
              end
            end
            nim_pkg::OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      nim_pkg::ST_FETCH: begin
        state_nxt = nim_pkg::ST_CMP;
      end

      nim_pkg::ST_CMP: begin
        priority if (is_desc) begin
          if (same_cur) begin
            cur_cnt_nxt = add_sum;
            state_nxt   = nim_pkg::ST_ACC;
          end else if (!have_r || out_free) begin
            // A new ancestor closes the previous merged entry.
            emit_entry   = have_r;
            have_nxt     = 1'b1;
            cur_pre_nxt  = a_rd_r.pre;
            cur_post_nxt = a_rd_r.post;
            cur_cnt_nxt  = nim_pkg::SUM_W'(b_rd_r.cnt);
            state_nxt    = nim_pkg::ST_ACC;
          end
        end else if (a_rd_r.pre < b_rd_r.pre) begin
          // Not a descendant: move on to the next A entry.
          i_nxt     = i_inc;
          state_nxt = (i_inc == len_a_r) ? nim_pkg::ST_FLUSH : nim_pkg::ST_FETCH;
        end else begin
          j_nxt     = j_inc;
          state_nxt = (j_inc == len_b_r) ? nim_pkg::ST_FLUSH : nim_pkg::ST_FETCH;
        end
      end

      nim_pkg::ST_ACC: begin
        total_nxt = add_sum;
        j_nxt     = j_inc;
        state_nxt = (j_inc == len_b_r) ? nim_pkg::ST_FLUSH : nim_pkg::ST_FETCH;
      end

      nim_pkg::ST_FLUSH: begin
        if (!have_r) begin
          state_nxt = nim_pkg::ST_SUMM;
        end else if (out_free) begin
          emit_entry = 1'b1;
          have_nxt   = 1'b0;
          state_nxt  = nim_pkg::ST_SUMM;
        end
      end

      nim_pkg::ST_SUMM: begin
        if (out_free) begin
          emit_summ = 1'b1;
          len_a_nxt = '0;
          len_b_nxt = '0;
          state_nxt = nim_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = nim_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_support_r <= '0;
    end else if (cfg_we) begin
      min_support_r <= cfg_wdata;
    end
  end

  // Output register: loads only when empty or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_entry || emit_summ) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_entry) begin
      out_pre_r  <= cur_pre_r;
      out_post_r <= cur_post_r;
      out_cnt_r  <= cur_cnt_r;
      out_summ_r <= 1'b0;
      out_tot_r  <= '0;
      out_freq_r <= 1'b0;
      out_last_r <= 1'b0;
    end else if (emit_summ) begin
      out_pre_r  <= '0;
      out_post_r <= '0;
      out_cnt_r  <= '0;
      out_summ_r <= 1'b1;
      out_tot_r  <= total_r;
      out_freq_r <= (total_r >= min_support_r);
      out_last_r <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pre_order     = out_pre_r;
  assign out_post_order    = out_post_r;
  assign out_count         = out_cnt_r;
  assign out_is_summary    = out_summ_r;
  assign out_total_support = out_tot_r;
  assign out_frequent      = out_freq_r;
  assign out_last          = out_last_r;

  // Pointers stay inside the loaded lists whenever the walk is in the fetch state.
  a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nim_pkg::ST_FETCH) |-> ((i_r < len_a_r) && (j_r < len_b_r)))
    else $error("walk pointer beyond list length");

  // A finished run leaves both lists empty and the block idle.
  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nim_pkg::ST_SUMM && out_free) |=>
      ((len_a_r == '0) && (len_b_r == '0) && (state_r == nim_pkg::ST_IDLE)))
    else $error("run end did not clear lists");

  // A merged entry word never carries summary fields.
  a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_summ_r) |-> (!out_last_r && !out_freq_r && (out_tot_r == '0)))
    else $error("entry word carries summary fields");

endmodule
